/* hdl/lifet_pkg.sv */
// Shared types and constants for the toroidal life automaton.
package lifet_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int CFG_W    = 7;
  localparam int IDX_IN_W = 12;
  localparam int OP_W     = 2;

  localparam logic [CFG_W-1:0] ROWS_RST = 7'd64;
  localparam logic [CFG_W-1:0] COLS_RST = 7'd64;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [3:0] LIVE_BIRTH = 4'd3;
  localparam logic [3:0] LIVE_KEEP  = 4'd2;

  // one read per neighborhood cell, center at step 4, write-back at step 9
  localparam logic [3:0] STEP_CENTER = 4'd4;
  localparam logic [3:0] STEP_LAST   = 4'd9;

  localparam logic [1:0] SEL_PREV = 2'd0;
  localparam logic [1:0] SEL_SAME = 2'd1;
  localparam logic [1:0] SEL_NEXT = 2'd2;

  typedef struct packed {
    logic clear;
    logic accept;
    logic gen_start;
    logic gen_run;
    logic copy_start;
    logic copy_run;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic gen_done;
    logic copy_done;
    logic out_free;
  } dp_sts_t;

endpackage

/* hdl/life_automaton_torus.sv */
// Write/read pass the DONE state, then the result register; the next item is taken after that.
// Advance makes nine reads of the single grid read port plus one write per cell,
// then a copy pass of one cell per cycle.
// Reset clears control state and runs a clearing pass over MAX_ROWS*MAX_COLS
// cells with s_axis_tready_o low; cfg writes are taken.
// rows and cols reset to 64.
module life_automaton_torus #(
  parameter int MAX_ROWS = lifet_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lifet_pkg::MAX_COLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [lifet_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [15:0]                 s_axis_tdata_i,  // op[1:0], cell_index[13:2], cell_value[14]
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o   // done_op[1:0], alive[2]
);

  lifet_pkg::dp_cmd_t         cmd;
  lifet_pkg::dp_sts_t         sts;
  logic [lifet_pkg::OP_W-1:0] out_op;
  logic                       out_alive;

  lifet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .op_i       (s_axis_tdata_i[1:0]),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lifet_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (s_axis_tdata_i[1:0]),
    .in_idx_i    (s_axis_tdata_i[13:2]),
    .in_val_i    (s_axis_tdata_i[14]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_op_o    (out_op),
    .out_alive_o (out_alive),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign m_axis_tdata_o = {5'd0, out_alive, out_op};

endmodule

/* hdl/lifet_ram.sv */
// Generic simple dual-port RAM with registered read.
module lifet_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/lifet_ctrl.sv */
// Control state machine for the life automaton.
module lifet_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic [lifet_pkg::OP_W-1:0]   op_i,
  output logic                         s_tready_o,
  input  lifet_pkg::dp_sts_t           sts_i,
  output lifet_pkg::dp_cmd_t           cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GEN,
    ST_COPY,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_tready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (op_i == lifet_pkg::OP_STEP) begin
            cmd_o.gen_start = 1'b1;
            state_d         = ST_GEN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_GEN: begin
        cmd_o.gen_run = 1'b1;
        if (sts_i.gen_done) begin
          cmd_o.copy_start = 1'b1;
          state_d          = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd_o.copy_run = 1'b1;
        if (sts_i.copy_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.load_out = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/lifet_dp.sv */
// Datapath: grid memories, neighbor sequencer, copy-back and result register.
module lifet_dp #(
  parameter int MAX_ROWS = lifet_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lifet_pkg::MAX_COLS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [lifet_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [lifet_pkg::OP_W-1:0]       in_op_i,
  input  logic [lifet_pkg::IDX_IN_W-1:0]   in_idx_i,
  input  logic                             in_val_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lifet_pkg::OP_W-1:0]       out_op_o,
  output logic                             out_alive_o,
  input  lifet_pkg::dp_cmd_t               cmd_i,
  output lifet_pkg::dp_sts_t               sts_o
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int SZ_W  = IDX_W + 1;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NR_W  = ROW_W + 1;
  localparam int NC_W  = COL_W + 1;
  localparam int CMP_W = (lifet_pkg::IDX_IN_W > SZ_W) ? lifet_pkg::IDX_IN_W : SZ_W;

  logic [lifet_pkg::CFG_W-1:0] rows_q, cols_q;
  logic [NR_W-1:0]             nr;
  logic [NC_W-1:0]             nc;
  logic [SZ_W-1:0]             size;
  logic                        in_range;
  logic [IDX_W-1:0]            in_addr;

  logic [lifet_pkg::OP_W-1:0]  op_q;
  logic                        range_q;
  logic                        out_v_q;
  logic [lifet_pkg::OP_W-1:0]  out_op_q;
  logic                        out_alive_q;

  logic [IDX_W-1:0]            clr_q;
  logic [ROW_W-1:0]            r_q;
  logic [COL_W-1:0]            c_q;
  logic [3:0]                  k_q;
  logic [3:0]                  cnt_q;
  logic [3:0]                  cnt_fin;
  logic                        center_q;
  logic [IDX_W-1:0]            lin_q;
  logic                        last_cell;
  logic [1:0]                  rsel_code, csel_code;
  logic [ROW_W-1:0]            rsel;
  logic [COL_W-1:0]            csel;
  logic [IDX_W-1:0]            nbr_addr;
  logic                        next_val;

  logic [SZ_W-1:0]             cp_q;
  logic                        cp_v_q;
  logic [IDX_W-1:0]            cp_a_q;

  logic                        g_we;
  logic [IDX_W-1:0]            g_waddr;
  logic                        g_wdata;
  logic [IDX_W-1:0]            g_raddr;
  logic                        g_rdata;
  logic                        n_we;
  logic                        n_rdata;

  // effective geometry
  always_comb begin
    if (rows_q < 7'd2) begin
      nr = NR_W'(2);
    end else if (32'(rows_q) > MAX_ROWS) begin
      nr = NR_W'(MAX_ROWS);
    end else begin
      nr = NR_W'(rows_q);
    end
    if (cols_q == '0) begin
      nc = NC_W'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      nc = NC_W'(MAX_COLS);
    end else begin
      nc = NC_W'(cols_q);
    end
  end

  assign size     = SZ_W'(SZ_W'(nr) * SZ_W'(nc));
  assign in_range = CMP_W'(in_idx_i) < CMP_W'(size);
  assign in_addr  = IDX_W'(CMP_W'(in_idx_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= lifet_pkg::ROWS_RST;
      cols_q <= lifet_pkg::COLS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lifet_pkg::REG_ROWS: rows_q <= cfg_data_i;
        lifet_pkg::REG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // neighbor offsets for the current step
  always_comb begin
    unique case (k_q)
      4'd0: begin rsel_code = lifet_pkg::SEL_PREV; csel_code = lifet_pkg::SEL_PREV; end
      4'd1: begin rsel_code = lifet_pkg::SEL_PREV; csel_code = lifet_pkg::SEL_SAME; end
      4'd2: begin rsel_code = lifet_pkg::SEL_PREV; csel_code = lifet_pkg::SEL_NEXT; end
      4'd3: begin rsel_code = lifet_pkg::SEL_SAME; csel_code = lifet_pkg::SEL_PREV; end
      4'd5: begin rsel_code = lifet_pkg::SEL_SAME; csel_code = lifet_pkg::SEL_NEXT; end
      4'd6: begin rsel_code = lifet_pkg::SEL_NEXT; csel_code = lifet_pkg::SEL_PREV; end
      4'd7: begin rsel_code = lifet_pkg::SEL_NEXT; csel_code = lifet_pkg::SEL_SAME; end
      4'd8: begin rsel_code = lifet_pkg::SEL_NEXT; csel_code = lifet_pkg::SEL_NEXT; end
      default: begin rsel_code = lifet_pkg::SEL_SAME; csel_code = lifet_pkg::SEL_SAME; end
    endcase
  end

  always_comb begin
    unique case (rsel_code)
      lifet_pkg::SEL_PREV: rsel = (r_q == '0) ? ROW_W'(nr - NR_W'(1)) : r_q - ROW_W'(1);
      lifet_pkg::SEL_NEXT: rsel = (NR_W'(r_q) == nr - NR_W'(1)) ? '0 : r_q + ROW_W'(1);
      default:             rsel = r_q;
    endcase
    unique case (csel_code)
      lifet_pkg::SEL_PREV: csel = (c_q == '0) ? COL_W'(nc - NC_W'(1)) : c_q - COL_W'(1);
      lifet_pkg::SEL_NEXT: csel = (NC_W'(c_q) == nc - NC_W'(1)) ? '0 : c_q + COL_W'(1);
      default:             csel = c_q;
    endcase
  end

  assign nbr_addr  = IDX_W'(SZ_W'(rsel) * SZ_W'(nc) + SZ_W'(csel));
  assign last_cell = (NR_W'(r_q) == nr - NR_W'(1)) && (NC_W'(c_q) == nc - NC_W'(1));
  assign cnt_fin   = cnt_q + 4'(g_rdata);
  assign next_val  = (cnt_fin == lifet_pkg::LIVE_BIRTH) ||
                     (center_q && (cnt_fin == lifet_pkg::LIVE_KEEP));
  assign n_we      = cmd_i.gen_run && (k_q == lifet_pkg::STEP_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q   <= '0;
      c_q   <= '0;
      k_q   <= '0;
      cnt_q <= '0;
      lin_q <= '0;
    end else if (cmd_i.gen_start) begin
      r_q   <= '0;
      c_q   <= '0;
      k_q   <= '0;
      cnt_q <= '0;
      lin_q <= '0;
    end else if (cmd_i.gen_run) begin
      if (k_q == lifet_pkg::STEP_LAST) begin
        k_q   <= '0;
        cnt_q <= '0;
        lin_q <= lin_q + IDX_W'(1);
        if (NC_W'(c_q) == nc - NC_W'(1)) begin
          c_q <= '0;
          r_q <= r_q + ROW_W'(1);
        end else begin
          c_q <= c_q + COL_W'(1);
        end
      end else begin
        k_q <= k_q + 4'd1;
        if (k_q != '0 && k_q != lifet_pkg::STEP_CENTER + 4'd1) begin
          cnt_q <= cnt_fin;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gen_run && k_q == lifet_pkg::STEP_CENTER + 4'd1) begin
      center_q <= g_rdata;
    end
  end

  // copy-back and reset clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q   <= '0;
      cp_v_q <= 1'b0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (cmd_i.copy_start) begin
        cp_q   <= '0;
        cp_v_q <= 1'b0;
      end else if (cmd_i.copy_run) begin
        cp_v_q <= (cp_q < size);
        if (cp_q < size) begin
          cp_q <= cp_q + SZ_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cp_a_q <= cp_q[IDX_W-1:0];
  end

  always_comb begin
    g_we    = 1'b0;
    g_waddr = in_addr;
    g_wdata = in_val_i;
    priority if (cmd_i.clear) begin
      g_we    = 1'b1;
      g_waddr = clr_q;
      g_wdata = 1'b0;
    end else if (cmd_i.accept && in_op_i == lifet_pkg::OP_WRITE) begin
      g_we = in_range;
    end else if (cmd_i.copy_run && cp_v_q) begin
      g_we    = 1'b1;
      g_waddr = cp_a_q;
      g_wdata = n_rdata;
    end
  end

  assign g_raddr = cmd_i.gen_run ? nbr_addr : in_addr;

  lifet_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  lifet_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_next (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (lin_q),
    .wdata_i (next_val),
    .raddr_i (cp_q[IDX_W-1:0]),
    .rdata_o (n_rdata)
  );

  // capture the item, then present its result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= in_op_i;
      range_q <= in_range;
    end
    if (cmd_i.load_out) begin
      out_op_q    <= op_q;
      out_alive_q <= (op_q == lifet_pkg::OP_READ) && range_q && g_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_v_q;
  assign out_op_o        = out_op_q;
  assign out_alive_o     = out_alive_q;
  assign sts_o.out_free   = !out_v_q || out_ready_i;
  assign sts_o.clear_done = (clr_q == IDX_W'(DEPTH - 1));
  assign sts_o.gen_done   = n_we && last_cell;
  assign sts_o.copy_done  = (cp_q == size) && !cp_v_q;

endmodule

/* hdl/lifet_chk.sv */
// Port-level checker for the life automaton, bound to the top level.
module lifet_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_alive_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != lifet_pkg::OP_READ |-> !m_axis_tdata_o[2])
    else $error("alive set on a non-read result");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:3] == 5'd0)
    else $error("result padding not zero");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("item taken while previous item in work");

endmodule

bind life_automaton_torus lifet_chk u_lifet_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

/* test/life_checker.sv */
// Checker for the toroidal life automaton: watches both streams, predicts each result, compares.
`timescale 1ns / 100ps
module life_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [lifet_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                        s_axis_tvalid_i,
  input  logic                        s_axis_tready_o,
  input  logic [15:0]                 s_axis_tdata_i,
  input  logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  input  logic [7:0]                  m_axis_tdata_o,
  output int                          fail_count_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [lifet_pkg::OP_W-1:0] done_op;
    logic                       alive;
  } life_result_t;

  logic [lifet_pkg::CFG_W-1:0] rows_reg, cols_reg;
  logic                        board [4096];
  life_result_t                expected_results [$];

  function automatic int eff_rows();
    if (rows_reg < 2) return 2;
    if (rows_reg > lifet_pkg::MAX_ROWS_DEF) return lifet_pkg::MAX_ROWS_DEF;
    return int'(rows_reg);
  endfunction

  function automatic int eff_cols();
    if (cols_reg < 1) return 1;
    if (cols_reg > lifet_pkg::MAX_COLS_DEF) return lifet_pkg::MAX_COLS_DEF;
    return int'(cols_reg);
  endfunction

  task automatic advance_generation();
    logic nxt [4096];
    int nr, nc, live, rr, cc;
    nr = eff_rows();
    nc = eff_cols();
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              rr = (r + dr + nr) % nr;
              cc = (c + dc + nc) % nc;
              live += board[rr * nc + cc];
            end
          end
        end
        nxt[r * nc + c] = (live == 3) || (board[r * nc + c] && live == 2);
      end
    end
    for (int k = 0; k < nr * nc; k++) board[k] = nxt[k];
  endtask

  task automatic report_mismatch(input string what);
    $display("checker: mismatch: %s", what);
    fail_count_o++;
  endtask

  assign pending_o = expected_results.size();

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    life_result_t                exp_r, got;
    logic [lifet_pkg::OP_W-1:0]  op;
    logic [11:0]                 idx;
    int                          size;
    if (!rst_ni) begin
      rows_reg = lifet_pkg::ROWS_RST;
      cols_reg = lifet_pkg::COLS_RST;
      foreach (board[k]) board[k] = 1'b0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.done_op = m_axis_tdata_o[1:0];
        got.alive   = m_axis_tdata_o[2];
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_axis_tdata_o));
        end else begin
          exp_r = expected_results.pop_front();
          if (got.done_op !== exp_r.done_op)
            report_mismatch($sformatf("done_op %0d want %0d", got.done_op, exp_r.done_op));
          if (got.alive !== exp_r.alive)
            report_mismatch($sformatf("alive %b want %b (op %0d)", got.alive, exp_r.alive,
                                      exp_r.done_op));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        op = s_axis_tdata_i[1:0];
        idx = s_axis_tdata_i[13:2];
        size = eff_rows() * eff_cols();
        exp_r.done_op = op;
        exp_r.alive = 1'b0;
        if (op == lifet_pkg::OP_WRITE) begin
          if (idx < size) board[idx] = s_axis_tdata_i[14];
        end else if (op == lifet_pkg::OP_STEP) begin
          advance_generation();
        end else if (op == lifet_pkg::OP_READ) begin
          if (idx < size) exp_r.alive = board[idx];
        end
        expected_results.push_back(exp_r);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == lifet_pkg::REG_ROWS) rows_reg = cfg_data_i;
        else cols_reg = cfg_data_i;
      end
    end
  end
endmodule

/* test/tb.sv */
// Testbench top for the toroidal life automaton: stimulus, phases of geometry and verdict.
`timescale 1ns / 100ps
module tb;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic                        cfg_idx_i = lifet_pkg::REG_ROWS;
  logic [lifet_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic                        s_axis_tvalid_i = 1'b0;
  logic                        s_axis_tready_o;
  logic [15:0]                 s_axis_tdata_i = '0;
  logic                        m_axis_tvalid_o;
  logic                        m_axis_tready_i = 1'b0;
  logic [7:0]                  m_axis_tdata_o;
  int                          fail_count, pending;
  int                          send_idle_pct = 35, recv_idle_pct = 58;
  longint                      cycle_count = 0;
  int                          cur_rows = 64, cur_cols = 64;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  life_automaton_torus dut (.*);

  life_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (cycle_count > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // valid stays high after the accept; the next item or an idle cycle drops it
  task automatic send_cell_op(input logic [1:0] op, input logic [11:0] idx, input logic val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {1'b0, val, idx, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [lifet_pkg::CFG_W-1:0] r,
                              input logic [lifet_pkg::CFG_W-1:0] c);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= lifet_pkg::REG_ROWS;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_idx_i <= lifet_pkg::REG_COLS;
    cfg_data_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_rows = (r < 2) ? 2 : (r > 64) ? 64 : r;
    cur_cols = (c < 1) ? 1 : (c > 64) ? 64 : c;
  endtask

  // mostly in-range cells, some beyond the grid and the full index range
  function automatic logic [11:0] pick_index();
    int k;
    k = $urandom_range(9);
    if (k < 7) return 12'($urandom_range(cur_rows * cur_cols - 1));
    if (k < 9) return 12'($urandom_range(4095, cur_rows * cur_cols));
    return 12'($urandom);
  endfunction

  task automatic random_burst(input int count);
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 50) send_cell_op(lifet_pkg::OP_WRITE, pick_index(), 1'($urandom));
      else if (k < 80) send_cell_op(lifet_pkg::OP_READ, pick_index(), 1'($urandom));
      else if (k < 90) send_cell_op(lifet_pkg::OP_STEP, 12'($urandom), 1'($urandom));
      else send_cell_op(lifet_pkg::OP_UNUSED, 12'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: blinker on a small torus, extremes of index, unused op
    set_geometry(7'd5, 7'd5);
    send_cell_op(lifet_pkg::OP_WRITE, 12'd11, 1'b1);
    send_cell_op(lifet_pkg::OP_WRITE, 12'd12, 1'b1);
    send_cell_op(lifet_pkg::OP_WRITE, 12'd13, 1'b1);
    send_cell_op(lifet_pkg::OP_WRITE, 12'd4095, 1'b1);
    send_cell_op(lifet_pkg::OP_READ, 12'd4095, 1'b0);
    send_cell_op(lifet_pkg::OP_READ, 12'd24, 1'b0);
    send_cell_op(lifet_pkg::OP_STEP, 12'd0, 1'b0);
    send_cell_op(lifet_pkg::OP_READ, 12'd7, 1'b0);
    send_cell_op(lifet_pkg::OP_READ, 12'd12, 1'b0);
    send_cell_op(lifet_pkg::OP_READ, 12'd25, 1'b0);
    send_cell_op(lifet_pkg::OP_UNUSED, 12'hFFF, 1'b1);
    send_cell_op(lifet_pkg::OP_WRITE, 12'd12, 1'b0);
    // clamped geometry: rows below 2, cols of 0, then above maximum
    set_geometry(7'd0, 7'd0);
    send_cell_op(lifet_pkg::OP_WRITE, 12'd0, 1'b1);
    send_cell_op(lifet_pkg::OP_STEP, 12'd0, 1'b0);
    send_cell_op(lifet_pkg::OP_READ, 12'd0, 1'b0);
    send_cell_op(lifet_pkg::OP_READ, 12'd1, 1'b0);
    set_geometry(7'd127, 7'd127);
    send_cell_op(lifet_pkg::OP_READ, 12'd4095, 1'b0);
    send_cell_op(lifet_pkg::OP_STEP, 12'd0, 1'b0);
    set_geometry(7'd2, 7'd3);
    random_burst(25);
    set_geometry(7'd4, 7'd1);
    random_burst(25);
    // hold off until the block has drained
    drain_results();
    send_idle_pct = 58;
    recv_idle_pct = 35;
    set_geometry(7'($urandom_range(2, 8)), 7'($urandom_range(1, 8)));
    random_burst(25);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_geometry(7'd3, 7'd6);
    random_burst(25);
    set_geometry(7'd64, 7'd64);
    random_burst(25);
    drain_results();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/lifet_pkg.sv
hdl/lifet_ram.sv
hdl/lifet_ctrl.sv
hdl/lifet_dp.sv
hdl/life_automaton_torus.sv
hdl/lifet_chk.sv
test/life_checker.sv
test/tb.sv
